[sv/osbc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package osbc_pkg;

  localparam int DAC_BITS_DEF = 12;

  localparam int CPU_W    = 10;
  localparam int DUTY_W   = 16;
  localparam int THR_W    = 16;
  localparam int VALUE_W  = 16;
  localparam int KIND_W   = 3;
  localparam int CFG_A_W  = 2;
  localparam int CFG_D_W  = 16;
  localparam int UV_PROD_W = VALUE_W + CPU_W;

  // x/30 == (x * 34953) >> 20 for every x below 2^16
  localparam int          RAMP_DIV    = 30;
  localparam int          RECIP_W     = 16;
  localparam int          RAMP_SHIFT  = 20;
  localparam logic [15:0] RAMP_RECIP  = 16'd34953;

  localparam logic [CPU_W-1:0]   CPU_RST      = 10'd280;
  localparam logic [DUTY_W-1:0]  DUTY_LIM_RST = 16'd14000;
  localparam logic [THR_W-1:0]   THR_RST      = 16'h0100;
  localparam logic [VALUE_W-1:0] UV_WIDTH_RST = 16'd40;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK          = 3'd0,
    KIND_LASER_ENABLE  = 3'd1,
    KIND_LASER_DISABLE = 3'd2,
    KIND_UV_ON         = 3'd3,
    KIND_UV_OFF        = 3'd4,
    KIND_UV_WIDTH      = 3'd5,
    KIND_PMT_GOAL      = 3'd6,
    KIND_MONITOR       = 3'd7
  } kind_t;

  typedef enum logic [CFG_A_W-1:0] {
    CFG_COUNTS_PER_US    = 2'd0,
    CFG_DUTY_LIMIT       = 2'd1,
    CFG_HEALTH_THRESHOLD = 2'd2
  } cfg_idx_t;

  function automatic int out_width(input int dac_bits);
    out_width = ((2 * dac_bits + DUTY_W + 4 + 7) / 8) * 8;
  endfunction

endpackage

`default_nettype wire

[sv/osbc_ramp.sv]
`timescale 1ns / 1ps
`default_nettype none

module osbc_ramp #(
  parameter int DAC_BITS = osbc_pkg::DAC_BITS_DEF
) (
  input  logic [DAC_BITS-1:0] present,
  input  logic [DAC_BITS-1:0] goal,
  output logic [DAC_BITS-1:0] stepped
);
  import osbc_pkg::*;

  localparam int PROD_W = DAC_BITS + RECIP_W;

  logic                       up;
  logic [DAC_BITS-1:0]        diff;
  logic [PROD_W-1:0]          prod;
  logic [PROD_W-RAMP_SHIFT-1:0] quot;
  logic [DAC_BITS-1:0]        step;

  always_comb begin
    up   = goal > present;
    diff = up ? (goal - present) : (present - goal);
    prod = PROD_W'(diff) * PROD_W'(RAMP_RECIP);
    quot = prod[PROD_W-1:RAMP_SHIFT];
    // diff/30 + 1 never exceeds diff once diff is nonzero, so no clamp
    step = DAC_BITS'(quot) + DAC_BITS'(1);
    if (present == goal) begin
      stepped = present;
    end else if (up) begin
      stepped = present + step;
    end else begin
      stepped = present - step;
    end
  end

endmodule

`default_nettype wire

[sv/optical_source_bias_controller_top.sv]
// An accepted item waits in the input register; its result loads into the
// result register once that register is empty or its result is taken.
// Throughput: one item per cycle; in_tready drops only while an item waits
// in the input register behind a result that out_tready holds back.
// Reset (rst_n low, synchronous) empties both registers and returns every
// flag, code and configuration register to its documented reset value.
`timescale 1ns / 1ps
`default_nettype none

module optical_source_bias_controller_top #(
  parameter int DAC_BITS = osbc_pkg::DAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [osbc_pkg::VALUE_W-1:0]            in_tdata,  // value
  input  logic [osbc_pkg::KIND_W-1:0]             in_tuser,  // kind
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // laser_dac, uv_duty, pmt_dac, ramp_busy, laser_is_on, uv_is_on,
  // laser_healthy, zero pad
  output logic [osbc_pkg::out_width(DAC_BITS)-1:0] out_tdata,
  input  logic                                    cfg_we,
  input  logic [osbc_pkg::CFG_A_W-1:0]            cfg_addr,
  input  logic [osbc_pkg::CFG_D_W-1:0]            cfg_wdata
);
  import osbc_pkg::*;

  localparam int          OUT_W   = out_width(DAC_BITS);
  localparam logic [VALUE_W:0] DAC_MAX = (VALUE_W+1)'((2 ** DAC_BITS) - 1);

  // input register
  logic                in_v_r;
  logic [KIND_W-1:0]   in_kind_r;
  logic [VALUE_W-1:0]  in_value_r;

  // configuration
  logic [CPU_W-1:0]    cpu_r;
  logic [DUTY_W-1:0]   duty_lim_r;
  logic [THR_W-1:0]    thr_r;

  // controller state
  logic                laser_en_r, laser_en_nxt;
  logic                uv_en_r, uv_en_nxt;
  logic [DAC_BITS-1:0] drive_r, drive_nxt;
  logic [VALUE_W-1:0]  uv_width_r, uv_width_nxt;
  logic [DAC_BITS-1:0] pmt_r, pmt_nxt;
  logic [DAC_BITS-1:0] goal_r, goal_nxt;
  logic                health_r, health_nxt;

  // result register
  logic                out_v_r;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic                advance;
  logic                in_accept;
  logic [DAC_BITS-1:0] value_sat;
  logic [DAC_BITS-1:0] pmt_stepped;
  logic [UV_PROD_W-1:0] uv_prod;
  logic [DUTY_W-1:0]   uv_duty;
  logic [DAC_BITS-1:0] laser_dac;

  assign advance   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || !out_v_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  osbc_ramp #(
    .DAC_BITS(DAC_BITS)
  ) u_ramp (
    .present (pmt_r),
    .goal    (goal_r),
    .stepped (pmt_stepped)
  );

  always_comb begin
    value_sat = ({1'b0, in_value_r} > DAC_MAX) ? DAC_MAX[DAC_BITS-1:0]
                                               : in_value_r[DAC_BITS-1:0];
    laser_en_nxt = laser_en_r;
    uv_en_nxt    = uv_en_r;
    drive_nxt    = drive_r;
    uv_width_nxt = uv_width_r;
    pmt_nxt      = pmt_r;
    goal_nxt     = goal_r;
    health_nxt   = health_r;
    case (kind_t'(in_kind_r))
      KIND_TICK:      pmt_nxt = pmt_stepped;
      KIND_LASER_ENABLE: begin
        drive_nxt    = value_sat;
        laser_en_nxt = 1'b1;
      end
      KIND_LASER_DISABLE: laser_en_nxt = 1'b0;
      KIND_UV_ON:     uv_en_nxt    = 1'b1;
      KIND_UV_OFF:    uv_en_nxt    = 1'b0;
      KIND_UV_WIDTH:  uv_width_nxt = in_value_r;
      KIND_PMT_GOAL:  goal_nxt     = value_sat;
      KIND_MONITOR:   health_nxt   = in_value_r > thr_r;
      default:        pmt_nxt      = pmt_r;
    endcase
  end

  always_comb begin
    uv_prod = UV_PROD_W'(uv_width_nxt) * UV_PROD_W'(cpu_r);
    if (!uv_en_nxt) begin
      uv_duty = '0;
    end else if (uv_prod > UV_PROD_W'(duty_lim_r)) begin
      uv_duty = duty_lim_r;
    end else begin
      uv_duty = uv_prod[DUTY_W-1:0];
    end
    laser_dac    = laser_en_nxt ? drive_nxt : '0;
    out_data_nxt = OUT_W'({health_nxt, uv_en_nxt, laser_en_nxt,
                           (pmt_nxt != goal_nxt), pmt_nxt, uv_duty, laser_dac});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      cpu_r      <= CPU_RST;
      duty_lim_r <= DUTY_LIM_RST;
      thr_r      <= THR_RST;
      laser_en_r <= 1'b0;
      uv_en_r    <= 1'b0;
      drive_r    <= '0;
      uv_width_r <= UV_WIDTH_RST;
      pmt_r      <= '0;
      goal_r     <= '0;
      health_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        in_v_r <= 1'b1;
      end else if (advance) begin
        in_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r    <= 1'b1;
        laser_en_r <= laser_en_nxt;
        uv_en_r    <= uv_en_nxt;
        drive_r    <= drive_nxt;
        uv_width_r <= uv_width_nxt;
        pmt_r      <= pmt_nxt;
        goal_r     <= goal_nxt;
        health_r   <= health_nxt;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_COUNTS_PER_US:    cpu_r      <= cfg_wdata[CPU_W-1:0];
          CFG_DUTY_LIMIT:       duty_lim_r <= cfg_wdata[DUTY_W-1:0];
          CFG_HEALTH_THRESHOLD: thr_r      <= cfg_wdata[THR_W-1:0];
          default:              cpu_r      <= cpu_r;  // unmapped index
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_kind_r  <= in_tuser;
      in_value_r <= in_tdata;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/osbc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module osbc_checker #(
  parameter int DAC_BITS = osbc_pkg::DAC_BITS_DEF
) (
  input wire logic                                    clk,
  input wire logic                                    rst_n,
  input wire logic                                    out_tvalid,
  input wire logic                                    out_tready,
  input wire logic [osbc_pkg::out_width(DAC_BITS)-1:0] out_tdata
);
  import osbc_pkg::*;

  localparam int DUTY_LO      = DAC_BITS;
  localparam int FLAG_LO      = 2 * DAC_BITS + DUTY_W;
  localparam int LASER_EN_BIT = FLAG_LO + 1;
  localparam int UV_EN_BIT    = FLAG_LO + 2;

  // a result held back must not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_laser_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[LASER_EN_BIT] |-> out_tdata[DAC_BITS-1:0] == '0)
    else $error("laser code nonzero while laser off");

  a_uv_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[UV_EN_BIT] |-> out_tdata[DUTY_LO +: DUTY_W] == '0)
    else $error("uv duty nonzero while uv off");

endmodule

bind optical_source_bias_controller_top osbc_checker #(
  .DAC_BITS(DAC_BITS)
) u_osbc_checker (.*);

`default_nettype wire

[verif/tb_optical_source_bias_controller_top.sv]
`timescale 1ns / 1ps

module tb_optical_source_bias_controller_top;
  import osbc_pkg::*;

  localparam int OUT_W          = out_width(DAC_BITS_DEF);
  localparam int DAC_TOP        = (1 << DAC_BITS_DEF) - 1;
  localparam int SOFT_START_DIV = 30;
  localparam int QUIET_LIMIT    = 2000;
  localparam int CHUNKS         = 6;
  localparam int CHUNK_ITEMS    = 130;
  localparam int DIR_ROWS       = 24;
  // cfg_addr value that maps to no register
  localparam logic [CFG_A_W-1:0] CFG_SPARE_IDX = 2'd3;

  // laser_dac in the low bits, pad on top (packed structs list MSB first)
  typedef struct packed {
    logic [3:0]  pad;
    logic        laser_healthy;
    logic        uv_is_on;
    logic        laser_is_on;
    logic        ramp_busy;
    logic [11:0] pmt_dac;
    logic [15:0] uv_duty;
    logic [11:0] laser_dac;
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] value;
    logic        pin;
    status_t     want;
  } dir_row_t;

  // Directed events; rows with pin set carry a hand-typed status, the rest
  // go through the predictor. Reset register values apply here.
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{KIND_TICK,          16'h0000, 1'b1, '{default: '0}},
    '{KIND_LASER_ENABLE,  16'hFFFF, 1'b1, '{laser_dac: 12'd4095, laser_is_on: 1'b1, default: '0}},
    '{KIND_LASER_ENABLE,  16'd100,  1'b1, '{laser_dac: 12'd100, laser_is_on: 1'b1, default: '0}},
    '{KIND_LASER_DISABLE, 16'hFFFF, 1'b1, '{default: '0}},
    '{KIND_LASER_ENABLE,  16'd4095, 1'b1, '{laser_dac: 12'd4095, laser_is_on: 1'b1, default: '0}},
    '{KIND_LASER_ENABLE,  16'd4096, 1'b1, '{laser_dac: 12'd4095, laser_is_on: 1'b1, default: '0}},
    '{KIND_LASER_DISABLE, 16'h0000, 1'b1, '{default: '0}},
    '{KIND_UV_WIDTH,      16'hFFFF, 1'b1, '{default: '0}},
    '{KIND_UV_ON,         16'h0000, 1'b1, '{uv_duty: 16'd14000, uv_is_on: 1'b1, default: '0}},
    '{KIND_UV_WIDTH,      16'd10,   1'b1, '{uv_duty: 16'd2800, uv_is_on: 1'b1, default: '0}},
    '{KIND_UV_WIDTH,      16'd0,    1'b1, '{uv_is_on: 1'b1, default: '0}},
    '{KIND_UV_WIDTH,      16'd50,   1'b1, '{uv_duty: 16'd14000, uv_is_on: 1'b1, default: '0}},
    '{KIND_UV_OFF,        16'hFFFF, 1'b1, '{default: '0}},
    '{KIND_PMT_GOAL,      16'hFFFF, 1'b1, '{ramp_busy: 1'b1, default: '0}},
    '{KIND_TICK,          16'h0000, 1'b0, '0},
    '{KIND_TICK,          16'hFFFF, 1'b0, '0},
    '{KIND_PMT_GOAL,      16'd100,  1'b0, '0},
    '{KIND_TICK,          16'h0000, 1'b0, '0},
    '{KIND_PMT_GOAL,      16'd263,  1'b0, '0},
    '{KIND_TICK,          16'h0000, 1'b0, '0},
    '{KIND_MONITOR,       16'd256,  1'b0, '0},
    '{KIND_MONITOR,       16'd257,  1'b0, '0},
    '{KIND_MONITOR,       16'hFFFF, 1'b0, '0},
    '{KIND_MONITOR,       16'h0000, 1'b0, '0}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [VALUE_W-1:0]  in_tdata = '0;   // value
  logic [KIND_W-1:0]   in_tuser = '0;   // kind
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;       // laser_dac, uv_duty, pmt_dac, flags, pad
  logic                cfg_we = 1'b0;
  logic [CFG_A_W-1:0]  cfg_addr = '0;
  logic [CFG_D_W-1:0]  cfg_wdata = '0;

  // travels with the item on the input side
  logic                row_pinned = 1'b0;
  status_t             row_want = '0;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  // predictor copy of registers and state
  logic [CPU_W-1:0]  cpu_reg   = CPU_RST;
  logic [DUTY_W-1:0] duty_reg  = DUTY_LIM_RST;
  logic [THR_W-1:0]  thr_reg   = THR_RST;
  logic              laser_en  = 1'b0;
  logic              uv_en     = 1'b0;
  logic [11:0]       drive_code = '0;
  logic [15:0]       uv_width  = UV_WIDTH_RST;
  logic [11:0]       pmt_now   = '0;
  logic [11:0]       pmt_goal  = '0;
  logic              healthy   = 1'b0;

  status_t pending_status [$];
  int n_accepted = 0;
  int n_checked  = 0;
  int n_fail     = 0;
  int n_settings = 1;
  int quiet_cycles = 0;

  optical_source_bias_controller_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [11:0] clamp_dac(logic [15:0] v);
    return (v > DAC_TOP) ? 12'(DAC_TOP) : v[11:0];
  endfunction

  function automatic status_t next_status(kind_t k, logic [15:0] v);
    logic [11:0] gap;
    logic [11:0] stride;
    logic [25:0] prod;
    status_t     s;
    case (k)
      KIND_TICK: begin
        if (pmt_now != pmt_goal) begin
          gap = (pmt_goal > pmt_now) ? pmt_goal - pmt_now : pmt_now - pmt_goal;
          stride = 12'(gap / SOFT_START_DIV) + 12'd1;
          if (stride > gap) stride = gap;
          pmt_now = (pmt_goal > pmt_now) ? pmt_now + stride : pmt_now - stride;
        end
      end
      KIND_LASER_ENABLE: begin
        drive_code = clamp_dac(v);
        laser_en = 1'b1;
      end
      KIND_LASER_DISABLE: laser_en = 1'b0;
      KIND_UV_ON:     uv_en = 1'b1;
      KIND_UV_OFF:    uv_en = 1'b0;
      KIND_UV_WIDTH:  uv_width = v;
      KIND_PMT_GOAL:  pmt_goal = clamp_dac(v);
      KIND_MONITOR:   healthy = (v > thr_reg);
    endcase
    prod = uv_width * cpu_reg;
    s = '0;
    s.laser_dac     = laser_en ? drive_code : '0;
    s.uv_duty       = !uv_en ? '0 : (prod > 26'(duty_reg)) ? duty_reg : prod[15:0];
    s.pmt_dac       = pmt_now;
    s.ramp_busy     = (pmt_now != pmt_goal);
    s.laser_is_on   = laser_en;
    s.uv_is_on      = uv_en;
    s.laser_healthy = healthy;
    return s;
  endfunction

  task automatic note_failure(string what, status_t e, status_t a);
    n_fail++;
    if (n_fail <= 10)
      $display("%0t %s: exp laser=%0d duty=%0d pmt=%0d busy=%0b on=%0b uv=%0b ok=%0b | got laser=%0d duty=%0d pmt=%0d busy=%0b on=%0b uv=%0b ok=%0b",
               $realtime, what, e.laser_dac, e.uv_duty, e.pmt_dac, e.ramp_busy,
               e.laser_is_on, e.uv_is_on, e.laser_healthy, a.laser_dac, a.uv_duty,
               a.pmt_dac, a.ramp_busy, a.laser_is_on, a.uv_is_on, a.laser_healthy);
  endtask

  // prediction on input items, comparison on output items, same edge order
  always @(posedge clk) begin : status_check
    status_t pred;
    status_t exp_s;
    status_t got_s;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_COUNTS_PER_US:    cpu_reg  = cfg_wdata[CPU_W-1:0];
          CFG_DUTY_LIMIT:       duty_reg = cfg_wdata;
          CFG_HEALTH_THRESHOLD: thr_reg  = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pred = next_status(kind_t'(in_tuser), in_tdata);
        pending_status.push_back(row_pinned ? row_want : pred);
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        got_s = out_tdata;
        n_checked++;
        if (pending_status.size() == 0) begin
          note_failure("unexpected item", '0, got_s);
        end else begin
          exp_s = pending_status.pop_front();
          if (exp_s.laser_dac != got_s.laser_dac || exp_s.uv_duty != got_s.uv_duty ||
              exp_s.pmt_dac != got_s.pmt_dac || exp_s.ramp_busy != got_s.ramp_busy ||
              exp_s.laser_is_on != got_s.laser_is_on || exp_s.uv_is_on != got_s.uv_is_on ||
              exp_s.laser_healthy != got_s.laser_healthy)
            note_failure("mismatch", exp_s, got_s);
        end
      end
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  task automatic send_event(kind_t k, logic [15:0] v, logic pin, status_t want);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= k;
    in_tdata   <= v;
    row_pinned <= pin;
    row_want   <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid  <= 1'b0;
    row_pinned <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_A_W-1:0] idx, logic [CFG_D_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
  endtask

  task automatic program_regs(logic [CFG_D_W-1:0] cpu, logic [CFG_D_W-1:0] duty,
                              logic [CFG_D_W-1:0] thr, bit poke_spare);
    wait_idle();
    cfg_write(CFG_COUNTS_PER_US, cpu);
    cfg_write(CFG_DUTY_LIMIT, duty);
    cfg_write(CFG_HEALTH_THRESHOLD, thr);
    if (poke_spare) cfg_write(CFG_SPARE_IDX, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Mostly legal control traffic; ticks dominate so PMT ramps run out.
  task automatic pick_event(output kind_t k, output logic [15:0] v);
    int r;
    int sel;
    r   = $urandom_range(0, 99);
    sel = $urandom_range(0, 3);
    v   = 16'($urandom);
    if (r < 30)      k = KIND_TICK;
    else if (r < 40) k = KIND_PMT_GOAL;
    else if (r < 50) k = KIND_LASER_ENABLE;
    else if (r < 55) k = KIND_LASER_DISABLE;
    else if (r < 63) k = KIND_UV_ON;
    else if (r < 70) k = KIND_UV_OFF;
    else if (r < 80) k = KIND_UV_WIDTH;
    else             k = KIND_MONITOR;
    case (k)
      KIND_PMT_GOAL, KIND_LASER_ENABLE: begin
        if (sel == 1) v = 16'($urandom_range(0, DAC_TOP));
        else if (sel == 2) v = 16'($urandom_range(0, 300));
        else if (sel == 3) v = 16'($urandom_range(DAC_TOP - 1, DAC_TOP + 2));
      end
      KIND_UV_WIDTH: if (sel != 0) v = 16'($urandom_range(0, 80));
      KIND_MONITOR: begin
        if (sel == 1) v = thr_reg;
        else if (sel == 2) v = thr_reg + 16'd1;
        else if (sel == 3) v = thr_reg - 16'd1;
      end
      default: ;
    endcase
  endtask

  initial begin : stimulus
    kind_t       k;
    logic [15:0] v;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    in_idle_pct   = 18;
    out_stall_pct = 68;
    for (int i = 0; i < DIR_ROWS; i++)
      send_event(DIRECTED[i].kind, DIRECTED[i].value, DIRECTED[i].pin, DIRECTED[i].want);

    for (int c = 0; c < CHUNKS; c++) begin
      case (c)
        0: program_regs(16'd1023, 16'hFFFF, 16'h0000, 1'b0);
        1: program_regs(16'd0, 16'h0000, 16'hFFFF, 1'b0);
        default: program_regs(16'($urandom_range(0, 1023)), 16'($urandom),
                              16'($urandom_range(0, 1023)), 1'b1);
      endcase
      // two chunks per idling profile: sender light, then receiver light, then none
      in_idle_pct   = (c < 2) ? 18 : (c < 4) ? 68 : 0;
      out_stall_pct = (c < 2) ? 68 : (c < 4) ? 18 : 0;
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        pick_event(k, v);
        send_event(k, v, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Ran %0d events (%0d directed) under %0d register settings and three stall profiles",
             n_accepted, DIR_ROWS, n_settings);
    $display("Compared %0d status items, %0d failures", n_checked, n_fail);
    if (n_fail == 0 && pending_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[sim.f]
sv/osbc_pkg.sv
sv/osbc_ramp.sv
sv/optical_source_bias_controller_top.sv
sv/osbc_checker.sv
verif/tb_optical_source_bias_controller_top.sv
